>>> rtl/fswl_pkg.sv
`timescale 1ns / 1ps

package fswl_pkg;

    // Default geometry of the word store
    localparam int SLOT_WORDS_DEF  = 16;
    localparam int STORE_WORDS_DEF = 512;

    // Word values with a meaning of their own
    localparam logic [15:0] ERASED_WORD = 16'hFFFF;
    localparam logic [15:0] SAT_WORD    = 16'hFFFE;

    // Operation codes of an input beat
    typedef enum logic [1:0] {
        OP_MOUNT    = 2'd0,
        OP_NEW_SLOT = 2'd1,
        OP_APPEND   = 2'd2,
        OP_READ     = 2'd3
    } op_t;

    // One result beat as it leaves the controller
    typedef struct packed {
        logic [15:0] read_word;
        logic [15:0] use_count;
        logic        status;
        logic        page_erased;
    } res_t;

    // Next use counter: erased head starts at zero, the top value saturates
    function automatic logic [15:0] bump_count(input logic [15:0] cnt);
        logic [15:0] res;
        if (cnt == ERASED_WORD)
            res = 16'd0;
        else if (cnt < SAT_WORD)
            res = cnt + 16'd1;
        else
            res = SAT_WORD;
        return res;
    endfunction

endpackage

>>> rtl/fswl_in_if.sv
`timescale 1ns / 1ps

interface fswl_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [5:0]  word_index;
    logic [15:0] write_word;

    modport source (output valid, output op, output word_index, output write_word,
                    input ready);
    modport sink   (input valid, input op, input word_index, input write_word,
                    output ready);
endinterface

>>> rtl/fswl_out_if.sv
`timescale 1ns / 1ps

interface fswl_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] read_word;
    logic [15:0] use_count;
    logic        status;
    logic        page_erased;

    modport source (output valid, output read_word, output use_count, output status,
                    output page_erased, input ready);
    modport sink   (input valid, input read_word, input use_count, input status,
                    input page_erased, output ready);
endinterface

>>> rtl/fswl_ram.sv
`timescale 1ns / 1ps

module fswl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
            rdata <= mem[raddr];
    end

endmodule

>>> rtl/fswl_ctrl.sv
`timescale 1ns / 1ps

module fswl_ctrl import fswl_pkg::*; #(
    parameter int SLOT_WORDS  = SLOT_WORDS_DEF,
    parameter int STORE_WORDS = STORE_WORDS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    fswl_in_if.sink                        items,
    output logic                           ram_we,
    output logic [$clog2(STORE_WORDS)-1:0] ram_waddr,
    output logic [15:0]                    ram_wdata,
    output logic                           ram_re,
    output logic [$clog2(STORE_WORDS)-1:0] ram_raddr,
    input  logic [15:0]                    ram_rdata,
    output res_t                           res,
    output logic                           res_valid,
    input  logic                           res_ready
);

    localparam int ADDR_W = $clog2(STORE_WORDS);
    localparam int POS_W  = $clog2(SLOT_WORDS + 1);
    localparam int WIDE_W = $clog2(STORE_WORDS + 2 * SLOT_WORDS + 64) + 1;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_HEAD_WR,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_HEAD_RD,
        S_HEAD_CHK,
        S_READ_WAIT,
        S_DONE
    } state_t;

    state_t              state_reg,      state_next;
    logic [ADDR_W-1:0]   slot_start_reg, slot_start_next;
    logic [POS_W-1:0]    append_pos_reg, append_pos_next;
    logic [15:0]         head_reg,       head_next;
    logic [15:0]         cnt_reg,        cnt_next;
    logic [WIDE_W-1:0]   scan_reg,       scan_next;
    logic [ADDR_W-1:0]   clr_reg,        clr_next;
    op_t                 op_reg,         op_next;
    logic [15:0]         rd_reg,         rd_next;
    logic                status_reg,     status_next;
    logic                erased_reg,     erased_next;
    logic                oob_reg,        oob_next;

    logic                accept;
    logic [WIDE_W-1:0]   app_addr;
    logic [WIDE_W-1:0]   rd_addr;
    logic [WIDE_W-1:0]   nxt_slot;
    logic [WIDE_W-1:0]   scan_prev;
    logic                wraps;

    // Handshake and address arithmetic
    assign items.ready = (state_reg == S_IDLE);
    assign accept      = items.valid && items.ready;
    assign app_addr    = WIDE_W'(slot_start_reg) + WIDE_W'(append_pos_reg);
    assign rd_addr     = WIDE_W'(slot_start_reg) + WIDE_W'(items.word_index) + WIDE_W'(1);
    assign nxt_slot    = WIDE_W'(slot_start_reg) + WIDE_W'(SLOT_WORDS);
    assign scan_prev   = scan_reg - WIDE_W'(SLOT_WORDS);
    assign wraps       = (nxt_slot >= WIDE_W'(STORE_WORDS));

    // Present the finished result
    assign res_valid       = (state_reg == S_DONE);
    assign res.read_word   = rd_reg;
    assign res.use_count   = head_reg;
    assign res.status      = status_reg;
    assign res.page_erased = erased_reg;

    // Sequence one operation through the store
    always_comb
    begin
        state_next      = state_reg;
        slot_start_next = slot_start_reg;
        append_pos_next = append_pos_reg;
        head_next       = head_reg;
        cnt_next        = cnt_reg;
        scan_next       = scan_reg;
        clr_next        = clr_reg;
        op_next         = op_reg;
        rd_next         = rd_reg;
        status_next     = status_reg;
        erased_next     = erased_reg;
        oob_next        = oob_reg;
        ram_we          = 1'b0;
        ram_waddr       = '0;
        ram_wdata       = ERASED_WORD;
        ram_re          = 1'b0;
        ram_raddr       = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                if (clr_reg == ADDR_W'(STORE_WORDS - 1))
                    state_next = erased_reg ? S_HEAD_WR : S_IDLE;
                else
                    clr_next = clr_reg + ADDR_W'(1);
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next     = op_t'(items.op);
                    status_next = 1'b0;
                    erased_next = 1'b0;
                    rd_next     = 16'd0;
                    unique case (op_t'(items.op))
                        OP_MOUNT:
                        begin
                            scan_next       = WIDE_W'(SLOT_WORDS);
                            append_pos_next = POS_W'(1);
                            state_next      = S_SCAN_RD;
                        end
                        OP_NEW_SLOT:
                        begin
                            cnt_next        = bump_count(head_reg);
                            append_pos_next = POS_W'(1);
                            if (wraps)
                            begin
                                slot_start_next = '0;
                                erased_next     = 1'b1;
                                clr_next        = '0;
                                state_next      = S_CLEAR;
                            end
                            else
                            begin
                                slot_start_next = nxt_slot[ADDR_W-1:0];
                                state_next      = S_HEAD_WR;
                            end
                        end
                        OP_APPEND:
                        begin
                            if (append_pos_reg >= POS_W'(SLOT_WORDS))
                                status_next = 1'b1;
                            else
                            begin
                                // drop words that fall beyond the store
                                ram_we          = (app_addr < WIDE_W'(STORE_WORDS));
                                ram_waddr       = app_addr[ADDR_W-1:0];
                                ram_wdata       = items.write_word;
                                append_pos_next = append_pos_reg + POS_W'(1);
                            end
                            state_next = S_DONE;
                        end
                        OP_READ:
                        begin
                            if (items.word_index >= 6'(SLOT_WORDS - 1))
                            begin
                                status_next = 1'b1;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = rd_addr[ADDR_W-1:0];
                                oob_next   = (rd_addr >= WIDE_W'(STORE_WORDS));
                                state_next = S_READ_WAIT;
                            end
                        end
                        default:
                            state_next = S_IDLE;
                    endcase
                end
            end
            S_HEAD_WR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = slot_start_reg;
                ram_wdata  = cnt_reg;
                head_next  = cnt_reg;
                state_next = S_DONE;
            end
            S_SCAN_RD:
            begin
                if (scan_reg >= WIDE_W'(STORE_WORDS))
                begin
                    slot_start_next = scan_prev[ADDR_W-1:0];
                    state_next      = S_HEAD_RD;
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = scan_reg[ADDR_W-1:0];
                    state_next = S_SCAN_CHK;
                end
            end
            S_SCAN_CHK:
            begin
                if (ram_rdata == ERASED_WORD)
                begin
                    slot_start_next = scan_prev[ADDR_W-1:0];
                    state_next      = S_HEAD_RD;
                end
                else
                begin
                    scan_next  = scan_reg + WIDE_W'(SLOT_WORDS);
                    state_next = S_SCAN_RD;
                end
            end
            S_HEAD_RD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = slot_start_reg;
                state_next = S_HEAD_CHK;
            end
            S_HEAD_CHK:
            begin
                head_next  = ram_rdata;
                state_next = S_DONE;
            end
            S_READ_WAIT:
            begin
                rd_next    = oob_reg ? ERASED_WORD : ram_rdata;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (res_ready)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // Hold state; reset starts a clearing pass over the store
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            slot_start_reg <= '0;
            append_pos_reg <= POS_W'(1);
            head_reg       <= ERASED_WORD;
            cnt_reg        <= 16'd0;
            scan_reg       <= '0;
            clr_reg        <= '0;
            op_reg         <= OP_MOUNT;
            rd_reg         <= 16'd0;
            status_reg     <= 1'b0;
            erased_reg     <= 1'b0;
            oob_reg        <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            slot_start_reg <= slot_start_next;
            append_pos_reg <= append_pos_next;
            head_reg       <= head_next;
            cnt_reg        <= cnt_next;
            scan_reg       <= scan_next;
            clr_reg        <= clr_next;
            op_reg         <= op_next;
            rd_reg         <= rd_next;
            status_reg     <= status_next;
            erased_reg     <= erased_next;
            oob_reg        <= oob_next;
        end
    end

`ifndef ASSERT_OFF
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        append_pos_reg != '0 && append_pos_reg <= POS_W'(SLOT_WORDS))
        else $error("append position out of range");

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        WIDE_W'(slot_start_reg) < WIDE_W'(STORE_WORDS))
        else $error("slot head beyond store");

    a_status_ops: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && status_reg |-> (op_reg == OP_APPEND || op_reg == OP_READ))
        else $error("ignored status on mount or new slot");

    a_erase_home: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && erased_reg |-> (op_reg == OP_NEW_SLOT && slot_start_reg == '0))
        else $error("erase result without return to first slot");

    a_wrap_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && op_t'(items.op) == OP_NEW_SLOT && wraps |=> state_reg == S_CLEAR)
        else $error("wrap did not start an erase pass");
`endif

endmodule

>>> rtl/fswl_out_reg.sv
`timescale 1ns / 1ps

module fswl_out_reg import fswl_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  res_t        res,
    input  logic        res_valid,
    output logic        res_ready,
    fswl_out_if.source  results
);

    logic full_reg, full_next;
    res_t data_reg;

    // Take a new beat when empty or when the held one leaves
    assign res_ready = !full_reg || results.ready;

    always_comb
    begin
        full_next = full_reg;
        if (res_valid && res_ready)
            full_next = 1'b1;
        else if (results.ready)
            full_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            full_reg <= 1'b0;
        else
            full_reg <= full_next;
    end

    // Hold the payload of the waiting beat
    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
            data_reg <= res;
    end

    assign results.valid       = full_reg;
    assign results.read_word   = data_reg.read_word;
    assign results.use_count   = data_reg.use_count;
    assign results.status      = data_reg.status;
    assign results.page_erased = data_reg.page_erased;

endmodule

>>> rtl/flash_slot_wear_leveler.sv
`timescale 1ns / 1ps

// Flash slot wear leveler: rotates records through fixed slots of a word RAM with
// one access per cycle. Each beat gives one result. A mount scans the slot heads
// up to the first erased one, and a read with an out-of-range index skips the RAM
// read; the other reads wait on the registered RAM read. A new slot that wraps
// erases the store in a sweep over every word before the new head is written.
// After reset the same sweep runs before the first beat is taken. A result waits
// in an output register, so the next beat can be taken meanwhile.
module flash_slot_wear_leveler import fswl_pkg::*; #(
    parameter int SLOT_WORDS  = SLOT_WORDS_DEF,
    parameter int STORE_WORDS = STORE_WORDS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    fswl_in_if.sink    items,
    fswl_out_if.source results
);

    localparam int ADDR_W = $clog2(STORE_WORDS);

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [15:0]       ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [15:0]       ram_rdata;
    res_t              res;
    logic              res_valid;
    logic              res_ready;

    // Operation sequencer
    fswl_ctrl #(
        .SLOT_WORDS  (SLOT_WORDS),
        .STORE_WORDS (STORE_WORDS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .items     (items),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .res       (res),
        .res_valid (res_valid),
        .res_ready (res_ready)
    );

    // Word store
    fswl_ram #(
        .WIDTH (16),
        .DEPTH (STORE_WORDS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Result register
    fswl_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res       (res),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .results   (results)
    );

endmodule
